>>> hdl/arsp_pkg.sv
package arsp_pkg;

   localparam int unsigned MaxPayloadDefault = 2048;
   localparam int unsigned MaxLineDefault    = 255;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  event_res;
      logic [7:0]  payload_byte;
      logic        payload_last;
      logic [11:0] payload_length;
      logic [31:0] client_ip;
      logic [15:0] client_port;
      logic [1:0]  link_state;
      logic        handshake_done;
      logic        accepted;
   } rsp_type;

   localparam logic [1:0] OP_RX     = 2'd0;
   localparam logic [1:0] OP_HEADER = 2'd1;
   localparam logic [1:0] OP_BODY   = 2'd2;
   localparam logic [1:0] OP_PLAIN  = 2'd3;

   localparam logic [1:0] LS_READY   = 2'd0;
   localparam logic [1:0] LS_SENDING = 2'd1;
   localparam logic [1:0] LS_AWAIT   = 2'd2;
   localparam logic [1:0] LS_ERROR   = 2'd3;

   localparam logic [3:0] EV_READY     = 4'd0;
   localparam logic [3:0] EV_RESTARTED = 4'd1;
   localparam logic [3:0] EV_OK        = 4'd2;
   localparam logic [3:0] EV_SEND_OK   = 4'd3;
   localparam logic [3:0] EV_ERROR     = 4'd4;
   localparam logic [3:0] EV_SEND_FAIL = 4'd5;
   localparam logic [3:0] EV_PROMPT    = 4'd6;
   localparam logic [3:0] EV_OTHER     = 4'd7;
   localparam logic [3:0] EV_PAYLOAD   = 4'd8;
   localparam logic [3:0] EV_HDR_ERROR = 4'd9;
   localparam logic [3:0] EV_COMMAND   = 4'd10;

   localparam int unsigned NumCand = 8;
   localparam int unsigned CandIpd = 0;
   localparam int unsigned CandPrompt = 1;
   localparam int unsigned CandReady = 2;
   localparam int unsigned CandRecv = 7;

   typedef enum logic [2:0] {
      MODE_LINE    = 3'b001,
      MODE_HEADER  = 3'b010,
      MODE_PAYLOAD = 3'b100
   } mode_type;

   // Candidate text character at a given line position, 8'h00 marks beyond end.
   function automatic logic [7:0] cand_char(input logic [2:0] c, input logic [3:0] p);
      logic [87:0] s;
      logic [3:0]  n;
      begin
         s = '0;
         n = 4'd0;
         unique case (c)
            3'd0: begin s[87:56] = "+IPD";            n = 4'd4;  end
            3'd1: begin s[87:72] = "> ";              n = 4'd2;  end
            3'd2: begin s[87:32] = "ready\r\n";       n = 4'd7;  end
            3'd3: begin s[87:56] = "OK\r\n";          n = 4'd4;  end
            3'd4: begin s[87:32] = "ERROR\r\n";       n = 4'd7;  end
            3'd5: begin s[87:16] = "SEND OK\r\n";     n = 4'd9;  end
            3'd6: begin s = "SEND FAIL\r\n";          n = 4'd11; end
            default: begin s[87:56] = "Recv";         n = 4'd4;  end
         endcase
         if (p < n) begin
            cand_char = s[8'd87 - {1'b0, p, 3'b000} -: 8];
         end else begin
            cand_char = 8'h00;
         end
      end
   endfunction

   function automatic logic [3:0] cand_len(input logic [2:0] c);
      begin
         unique case (c)
            3'd0: cand_len = 4'd4;
            3'd1: cand_len = 4'd2;
            3'd2: cand_len = 4'd7;
            3'd3: cand_len = 4'd4;
            3'd4: cand_len = 4'd7;
            3'd5: cand_len = 4'd9;
            3'd6: cand_len = 4'd11;
            default: cand_len = 4'd4;
         endcase
      end
   endfunction

endpackage

>>> hdl/arsp_line_match.sv
module arsp_line_match #(
   parameter int unsigned LineW = 8
) (
   input  logic [LineW-1:0] line_pos,
   input  logic [7:0]       match_mask,
   input  logic [7:0]       rx_byte,
   output logic [7:0]       next_mask
);
   import arsp_pkg::*;

   always_comb begin
      next_mask = '0;
      for (int i = 0; i < NumCand; i++) begin
         if (match_mask[i]) begin
            if (line_pos < LineW'(cand_len(3'(i)))) begin
               if (cand_char(3'(i), line_pos[3:0]) == rx_byte) begin
                  next_mask[i] = 1'b1;
               end
            end else if (i == CandRecv) begin
               next_mask[i] = 1'b1;
            end
         end
      end
   end
endmodule

>>> hdl/at_response_stream_parser_top.sv
// AT response stream parser.
// Input channel req_*: one transaction carries an opcode and a received byte.
// Opcode received byte feeds the line, header or payload parser; the three
// command opcodes report whether the command is allowed and update link state.
// Output channel rsp_*: zero or one transaction per input transaction, carrying
// the event code, payload byte and last mark, and a snapshot of the parsed
// header fields and link status.
// A result is registered at the edge that accepts the input. One transaction is
// accepted every cycle while the result register is free or being emptied; the parse
// state is updated by combinational logic between the input and the result register.
// When the receiver stalls, the result register holds and req_ready drops
// only while it is full and not being emptied.
// Synchronous reset returns the parser to line mode with all candidates live,
// clears the accumulators, sets the link to ready and clears the ready and
// handshake flags. No transaction is accepted during reset.
module at_response_stream_parser_top #(
   parameter int unsigned MAX_PAYLOAD = arsp_pkg::MaxPayloadDefault,
   parameter int unsigned MAX_LINE    = arsp_pkg::MaxLineDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  arsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output arsp_pkg::rsp_type rsp_data
);
   import arsp_pkg::*;

   localparam int unsigned LineW = $clog2(MAX_LINE + 1);
   localparam int unsigned LenW  = $clog2(MAX_PAYLOAD + 2);
   localparam logic [LenW-1:0] LenCap = LenW'(MAX_PAYLOAD + 1);
   localparam logic [LenW-1:0] LenMax = LenW'(MAX_PAYLOAD);
   localparam logic [LineW-1:0] LineMax = LineW'(MAX_LINE);

   mode_type         mode_ff, mode_in;
   logic [LineW-1:0] pos_ff, pos_in;
   logic [7:0]       mask_ff, mask_in, mask_next;
   logic [1:0]       comma_ff, comma_in;
   logic [LenW-1:0]  len_ff, len_in, remain_ff, remain_in;
   logic [16:0]      port_ff, port_in;
   logic [7:0]       octet_ff, octet_in;
   logic [31:0]      ip_ff, ip_in;
   logic [1:0]       link_ff, link_in;
   logic             seen_ff, seen_in, hs_ff, hs_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic       fire, emit;
   logic [3:0] ev;
   logic       ok, last, digit;
   logic [3:0] d;
   logic [7:0] b;
   logic [LenW+3:0] len_mul;
   logic [20:0] port_mul;
   logic [11:0] oct_mul;
   logic       whole_hit;
   logic [3:0] whole_ev;
   logic       whole_ready;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign fire      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign b         = req_data.rx_byte;
   assign digit     = (b >= 8'h30) && (b <= 8'h39);
   assign d         = b[3:0];

   arsp_line_match #(.LineW(LineW)) u_match (
      .line_pos  (pos_ff),
      .match_mask(mask_ff),
      .rx_byte   (b),
      .next_mask (mask_next)
   );

   assign len_mul  = (LenW+4)'(len_ff) * (LenW+4)'(10) + (LenW+4)'(d);
   assign port_mul = 21'(port_ff) * 21'd10 + 21'(d);
   assign oct_mul  = 12'(octet_ff) * 12'd10 + 12'(d);

   // First whole-line candidate whose full text ends on this byte.
   always_comb begin
      whole_hit   = 1'b0;
      whole_ev    = EV_OTHER;
      whole_ready = 1'b0;
      for (int i = 6; i >= 2; i--) begin
         if (mask_next[i] && ((LineW+1)'(pos_ff) + 1'b1 == (LineW+1)'(cand_len(3'(i))))) begin
            whole_hit = 1'b1;
            whole_ready = (i == CandReady);
            unique case (i)
               3: whole_ev = EV_OK;
               4: whole_ev = EV_ERROR;
               5: whole_ev = EV_SEND_OK;
               6: whole_ev = EV_SEND_FAIL;
               default: whole_ev = EV_READY;
            endcase
         end
      end
   end

   always_comb begin
      mode_in = mode_ff; pos_in = pos_ff; mask_in = mask_ff; comma_in = comma_ff;
      len_in = len_ff; remain_in = remain_ff; port_in = port_ff; octet_in = octet_ff;
      ip_in = ip_ff; link_in = link_ff; seen_in = seen_ff; hs_in = hs_ff;
      emit = 1'b0; ev = EV_OTHER; ok = 1'b0; last = 1'b0;

      if (req_data.opcode != OP_RX) begin
         unique case (req_data.opcode)
            OP_HEADER: ok = hs_ff && (link_ff == LS_READY);
            OP_BODY:   ok = hs_ff && (link_ff == LS_AWAIT);
            default:   ok = 1'b1;
         endcase
         if (ok) begin
            link_in = LS_SENDING;
         end
         emit = 1'b1;
         ev = EV_COMMAND;
      end else begin
         unique case (mode_ff)
            MODE_PAYLOAD: begin
               last = (remain_ff <= LenW'(1));
               emit = 1'b1;
               ev = EV_PAYLOAD;
               if (last) begin
                  remain_in = '0;
                  mode_in = MODE_LINE;
                  pos_in = '0;
                  mask_in = '1;
               end else begin
                  remain_in = remain_ff - 1'b1;
               end
            end
            MODE_HEADER: begin
               if (b == 8'h3A) begin
                  hs_in = 1'b1;
                  if (len_ff == '0 || len_ff > LenMax) begin
                     mode_in = MODE_LINE;
                     pos_in = '0;
                     mask_in = '1;
                     emit = 1'b1;
                     ev = EV_HDR_ERROR;
                  end else begin
                     remain_in = len_ff;
                     mode_in = MODE_PAYLOAD;
                  end
               end else if (b == 8'h2C) begin
                  if (comma_ff == 2'd2) begin
                     ip_in = {ip_ff[23:0], octet_ff};
                     octet_in = '0;
                  end
                  if (comma_ff != 2'd3) begin
                     comma_in = comma_ff + 1'b1;
                  end
               end else if (comma_ff == 2'd1 && digit) begin
                  len_in = (len_ff > LenCap || len_mul > (LenW+4)'(LenCap)) ? LenCap
                           : len_mul[LenW-1:0];
               end else if (comma_ff == 2'd2) begin
                  if (digit) begin
                     octet_in = (oct_mul > 12'd255) ? 8'd255 : oct_mul[7:0];
                  end else if (b == 8'h2E) begin
                     ip_in = {ip_ff[23:0], octet_ff};
                     octet_in = '0;
                  end
               end else if (comma_ff == 2'd3 && digit) begin
                  port_in = (port_ff > 17'd65535 || port_mul > 21'd65535) ? 17'd65535
                            : port_mul[16:0];
               end
            end
            default: begin
               mask_in = mask_next;
               if (mask_next[CandIpd] && pos_ff == LineW'(3)) begin
                  mode_in = MODE_HEADER;
                  comma_in = '0; len_in = '0; port_in = '0; octet_in = '0; ip_in = '0;
                  pos_in = '0;
                  mask_in = '1;
               end else if (mask_next[CandPrompt] && pos_ff == LineW'(1)) begin
                  link_in = LS_AWAIT;
                  pos_in = '0;
                  mask_in = '1;
                  emit = 1'b1;
                  ev = EV_PROMPT;
               end else if (b == 8'h0A) begin
                  emit = 1'b1;
                  ev = whole_ev;
                  if (whole_hit && whole_ready) begin
                     ev = seen_ff ? EV_RESTARTED : EV_READY;
                     seen_in = 1'b1;
                  end else if (whole_hit && (whole_ev == EV_OK || whole_ev == EV_SEND_OK)) begin
                     link_in = LS_READY;
                  end else if (whole_hit && whole_ev == EV_ERROR) begin
                     link_in = LS_ERROR;
                  end else if (whole_hit && whole_ev == EV_SEND_FAIL) begin
                     port_in = '0; ip_in = '0; hs_in = 1'b0; link_in = LS_ERROR;
                  end else if (mask_next[CandRecv] && pos_ff >= LineW'(4)) begin
                     emit = 1'b0;
                  end
                  pos_in = '0;
                  mask_in = '1;
               end else if (pos_ff < LineMax) begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         endcase
      end
   end

   // Result snapshot uses the state after the transaction, as the fields are read post-update.
   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
         rsp_in.event_res      = ev;
         rsp_in.payload_byte   = (ev == EV_PAYLOAD) ? b : 8'h00;
         rsp_in.payload_last   = last;
         rsp_in.payload_length = 12'(len_in);
         rsp_in.client_ip      = ip_in;
         rsp_in.client_port    = port_in[15:0];
         rsp_in.link_state     = link_in;
         rsp_in.handshake_done = hs_in;
         rsp_in.accepted       = ok;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         mode_ff <= MODE_LINE; pos_ff <= '0; mask_ff <= '1; comma_ff <= '0;
         len_ff <= '0; remain_ff <= '0; port_ff <= '0; octet_ff <= '0; ip_ff <= '0;
         link_ff <= LS_READY; seen_ff <= 1'b0; hs_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            mode_ff <= mode_in; pos_ff <= pos_in; mask_ff <= mask_in; comma_ff <= comma_in;
            len_ff <= len_in; remain_ff <= remain_in; port_ff <= port_in;
            octet_ff <= octet_in; ip_ff <= ip_in; link_ff <= link_in;
            seen_ff <= seen_in; hs_ff <= hs_in;
         end
      end
   end
endmodule

>>> test/at_response_stream_parser_top_tb.sv
`timescale 1ns / 1ps

class parser_scoreboard;
   // Predicted parser state.
   arsp_pkg::mode_type mode;
   int unsigned line_pos;
   logic [7:0]  live_mask;
   int unsigned commas;
   int unsigned len_acc;
   int unsigned port_acc;
   int unsigned octet_acc;
   logic [31:0] ip_reg;
   int unsigned remaining;
   logic [1:0]  link;
   bit          ready_seen;
   bit          handshaken;
   arsp_pkg::rsp_type pending[$];
   int unsigned errors;
   int unsigned checked;
   int unsigned payload_count;

   function void clear();
      mode = arsp_pkg::MODE_LINE; line_pos = 0; live_mask = 8'hFF; commas = 0;
      len_acc = 0; port_acc = 0; octet_acc = 0; ip_reg = '0; remaining = 0;
      link = arsp_pkg::LS_READY; ready_seen = 0; handshaken = 0;
      pending.delete(); errors = 0; checked = 0; payload_count = 0;
   endfunction

   function string phrase(int c);
      case (c)
         0: phrase = "+IPD";
         1: phrase = "> ";
         2: phrase = "ready\r\n";
         3: phrase = "OK\r\n";
         4: phrase = "ERROR\r\n";
         5: phrase = "SEND OK\r\n";
         6: phrase = "SEND FAIL\r\n";
         default: phrase = "Recv";
      endcase
   endfunction

   function int unsigned sat(int unsigned acc, int unsigned d, int unsigned cap);
      int unsigned v;
      v = acc * 10 + d;
      if (acc > cap || v > cap) v = cap;
      return v;
   endfunction

   function void push(logic [3:0] ev, logic [7:0] pb, bit last, bit ok);
      arsp_pkg::rsp_type r;
      r.event_res = ev; r.payload_byte = pb; r.payload_last = last;
      r.payload_length = len_acc[11:0]; r.client_ip = ip_reg;
      r.client_port = port_acc[15:0]; r.link_state = link;
      r.handshake_done = handshaken; r.accepted = ok;
      pending.push_back(r);
   endfunction

   function void restart_line();
      line_pos = 0; live_mask = 8'hFF;
   endfunction

   function void note_line_byte(logic [7:0] b);
      logic [7:0] m;
      string s;
      logic [3:0] ev;
      int i;
      bit silent;
      m = '0;
      for (i = 0; i < 8; i++) begin
         s = phrase(i);
         if (live_mask[i]) begin
            if (line_pos < s.len()) begin
               if (s[line_pos] == b) m[i] = 1'b1;
            end else if (i == arsp_pkg::CandRecv) begin
               m[i] = 1'b1;
            end
         end
      end
      live_mask = m;
      if (m[arsp_pkg::CandIpd] && line_pos == 3) begin
         mode = arsp_pkg::MODE_HEADER; commas = 0; len_acc = 0; port_acc = 0;
         octet_acc = 0; ip_reg = '0; restart_line();
         return;
      end
      if (m[arsp_pkg::CandPrompt] && line_pos == 1) begin
         link = arsp_pkg::LS_AWAIT; restart_line();
         push(arsp_pkg::EV_PROMPT, 8'd0, 0, 0);
         return;
      end
      if (b == 8'h0A) begin
         ev = arsp_pkg::EV_OTHER;
         for (i = 2; i <= 6; i++) begin
            s = phrase(i);
            if (m[i] && line_pos + 1 == s.len()) break;
         end
         case (i)
            2: begin
               ev = ready_seen ? arsp_pkg::EV_RESTARTED : arsp_pkg::EV_READY;
               ready_seen = 1;
            end
            3: begin ev = arsp_pkg::EV_OK; link = arsp_pkg::LS_READY; end
            4: begin ev = arsp_pkg::EV_ERROR; link = arsp_pkg::LS_ERROR; end
            5: begin ev = arsp_pkg::EV_SEND_OK; link = arsp_pkg::LS_READY; end
            6: begin
               ev = arsp_pkg::EV_SEND_FAIL; port_acc = 0; ip_reg = '0;
               handshaken = 0; link = arsp_pkg::LS_ERROR;
            end
            default: ;
         endcase
         silent = (i == 7) && m[arsp_pkg::CandRecv] && (line_pos >= 4);
         restart_line();
         // A line that opens with Recv is swallowed silently.
         if (silent) return;
         push(ev, 8'd0, 0, 0);
         return;
      end
      if (line_pos < 255) line_pos++;
   endfunction

   function void note_header_byte(logic [7:0] b);
      bit dig;
      int unsigned d;
      dig = (b >= "0" && b <= "9");
      d = b - "0";
      if (b == ":") begin
         handshaken = 1;
         if (len_acc == 0 || len_acc > 2048) begin
            mode = arsp_pkg::MODE_LINE; restart_line();
            push(arsp_pkg::EV_HDR_ERROR, 8'd0, 0, 0);
         end else begin
            remaining = len_acc; mode = arsp_pkg::MODE_PAYLOAD;
         end
         return;
      end
      if (b == ",") begin
         if (commas == 2) begin ip_reg = {ip_reg[23:0], octet_acc[7:0]}; octet_acc = 0; end
         if (commas < 3) commas++;
         return;
      end
      if (commas == 1 && dig) len_acc = sat(len_acc, d, 2049);
      else if (commas == 2) begin
         if (dig) octet_acc = sat(octet_acc, d, 255);
         else if (b == ".") begin ip_reg = {ip_reg[23:0], octet_acc[7:0]}; octet_acc = 0; end
      end else if (commas == 3 && dig) port_acc = sat(port_acc, d, 65535);
   endfunction

   function void note_request(arsp_pkg::req_type q);
      bit ok;
      if (q.opcode != arsp_pkg::OP_RX) begin
         if (q.opcode == arsp_pkg::OP_HEADER)
            ok = handshaken && link == arsp_pkg::LS_READY;
         else if (q.opcode == arsp_pkg::OP_BODY)
            ok = handshaken && link == arsp_pkg::LS_AWAIT;
         else ok = 1;
         if (ok) link = arsp_pkg::LS_SENDING;
         push(arsp_pkg::EV_COMMAND, 8'd0, 0, ok);
      end else if (mode == arsp_pkg::MODE_PAYLOAD) begin
         if (remaining <= 1) begin
            remaining = 0; mode = arsp_pkg::MODE_LINE; restart_line();
            push(arsp_pkg::EV_PAYLOAD, q.rx_byte, 1, 0);
         end else begin
            remaining--;
            push(arsp_pkg::EV_PAYLOAD, q.rx_byte, 0, 0);
         end
         payload_count++;
      end else if (mode == arsp_pkg::MODE_HEADER) note_header_byte(q.rx_byte);
      else note_line_byte(q.rx_byte);
   endfunction

   function void check_result(arsp_pkg::rsp_type got);
      arsp_pkg::rsp_type want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
         $display("%0t: mismatch, expected %h, actual %h", $time, want, got);
         if (got.event_res !== want.event_res)
            $display("%0t:   event expected %0d, actual %0d", $time,
                     want.event_res, got.event_res);
         errors++;
      end
   endfunction
endclass

module at_response_stream_parser_top_tb;
   import arsp_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;

   parser_scoreboard board;
   int unsigned cycle_count = 0;
   bit      calm = 0;

   at_response_stream_parser_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_valid && req_ready) board.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
      if (cycle_count > 400000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= calm || ($urandom_range(99) >= 23);
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send(logic [1:0] op, logic [7:0] b);
      if (!calm) begin
         while ($urandom_range(99) < 23) begin
            req_valid <= 0;
            @(negedge clock);
         end
      end
      req_data <= '{opcode: op, rx_byte: b};
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      foreach (s[i]) send(OP_RX, s[i]);
   endtask

   task automatic send_datagram(int unsigned n, bit broken);
      string h;
      h = $sformatf("+IPD,%0d,%0d.%0d.%0d.%0d,%0d:", n, $urandom_range(255),
                    $urandom_range(300), $urandom_range(255), $urandom_range(255),
                    $urandom_range(70000));
      if (broken) h = $sformatf("+IPD,0,%0d,x:", $urandom_range(99));
      send_text(h);
      if (!broken) repeat (n) send(OP_RX, 8'($urandom_range(255)));
   endtask

   initial begin
      int unsigned k;
      board = new();
      board.clear();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed part: each line kind, prompt, commands and header extremes.
      send_text("ready\r\n");
      send_text("ready\r\n");
      send(OP_HEADER, 8'h00);
      send_text("+IPD,1,255.0.0.1,65535:");
      send(OP_RX, 8'hFF);
      send_text("> ");
      send(OP_BODY, 8'h00);
      send_text("SEND OK\r\n");
      send(OP_HEADER, 8'hFF);
      send_text("OK\r\nERROR\r\nSEND FAIL\r\nRecv 5\r\n\n");
      send(OP_PLAIN, 8'h55);
      send_text("+IPD,9999,1.2.3.4,99999:");
      send_text("+IPD,0,,:");
      send_text("+IPD,200,999.1.2.3,5,6:");
      repeat (200) send(OP_RX, 8'h00);
      send(OP_RX, 8'h0A);

      calm = 1;
      for (k = 0; k < 150; k++) send(OP_RX, 8'($urandom_range(255)));
      calm = 0;

      for (k = 0; k < 25; k++) begin
         case ($urandom_range(9))
            0: send_text("ready\r\n");
            1: send_text("OK\r\n");
            2: send_text("SEND OK\r\n");
            3: send_text("ERROR\r\n");
            4: send_text("SEND FAIL\r\n");
            5: send_text("> ");
            6: send_datagram($urandom_range(1, 12), $urandom_range(3) == 0);
            7: send(2'($urandom_range(1, 3)), 8'($urandom_range(255)));
            8: send_text("Recv 12 bytes\r\n");
            default: repeat ($urandom_range(1, 6)) send(OP_RX, 8'($urandom_range(255)));
         endcase
      end
      req_valid <= 0;

      k = 0;
      while (board.pending.size() != 0 && k < 5000) begin
         @(posedge clock);
         k++;
      end
      repeat (10) @(posedge clock);
      $display("Covered every line kind, prompts, commands, %0d payload bytes;",
               board.payload_count);
      $display("%0d transactions checked, %0d mismatches.", board.checked, board.errors);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
